// File: rtl/bce_pkg.sv
// shared constants and types for the bezier curve evaluator
package bce_pkg;

  // width of the point count register
  localparam int CNT_BITS = 3;
  // configuration port widths
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 48;
  // width of the t field on the input stream, and its byte-padded bus
  localparam int T_BITS = 17;
  localparam int IN_DATA_BITS = 24;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_POINT_COUNT = 3'd0,
    REG_POINT_ZERO  = 3'd1,
    REG_POINT_ONE   = 3'd2,
    REG_POINT_TWO   = 3'd3,
    REG_POINT_THREE = 3'd4,
    REG_POINT_FOUR  = 3'd5,
    REG_POINT_FIVE  = 3'd6,
    REG_POINT_SIX   = 3'd7
  } cfg_reg_t;

endpackage

// File: rtl/bezier_curve_evaluator.sv
// bezier curve evaluator: pipelined de casteljau ladder over up to MAX_POINTS control points
//
// Takes one curve parameter t (unsigned, FRAC_BITS fraction bits, values above 1.0
// saturate) per clock while in_tready is high and returns the 3D curve point,
// each coordinate rounded to nearest with ties upward. The pipeline is one capture
// stage plus MAX_POINTS-1 blend stages, one de casteljau level per stage;
// throughput is one item per cycle unless the output stalls. Each blend stage holds one
// 17x16 multiply pair per coordinate in every lane but the last, followed by a register,
// and every stage has its own valid bit and ready, so bubbles close up under output stall.
// Levels beyond point_count-1 pass their data through unchanged. Control points
// and point_count are written on the cfg port and must only change while idle.
module bezier_curve_evaluator #(
  parameter int MAX_POINTS = 7,
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream; tdata: t_fraction[16:0], zero pad
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bce_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // output stream; tdata: pos_x, pos_y, pos_z from the lowest bit up, zero pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((3*COORD_BITS+7)/8)*8-1:0]  out_tdata,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bce_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [bce_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int STAGES  = MAX_POINTS - 1;
  localparam int OUT_W   = ((3*COORD_BITS+7)/8)*8;
  localparam int PAD_W   = OUT_W - 3*COORD_BITS;
  localparam int PI_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SUM_W   = FRAC_BITS + COORD_BITS + 3;
  localparam logic [31:0] ONE_T = 32'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS-1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // configuration registers
  logic [bce_pkg::CNT_BITS-1:0] cnt_r;
  coord_t                       pts_r [MAX_POINTS][3];

  // pipeline registers, stage 0 is capture, stage STAGES is the output
  logic                 v_r [STAGES+1];
  logic [FRAC_BITS:0]   t_r [STAGES+1];
  coord_t               q_r [STAGES+1][MAX_POINTS][3];
  coord_t               q_nxt [STAGES+1][MAX_POINTS][3];
  logic                 rdy [STAGES+1];
  logic                 lvl_en [STAGES+1];

  logic [bce_pkg::CNT_BITS-1:0] cnt_eff;
  logic [31:0]                  tin;
  logic [FRAC_BITS:0]           t_sat;
  logic [63:0]                  cfg_wide;
  logic [bce_pkg::CFG_ADDR_BITS-1:0] pidx;

  // configuration write port
  assign cfg_ready = 1'b1;
  assign cfg_wide  = 64'(cfg_data);
  assign pidx      = cfg_addr - bce_pkg::CFG_ADDR_BITS'(bce_pkg::REG_POINT_ZERO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= bce_pkg::CNT_BITS'(1);
      for (int p = 0; p < MAX_POINTS; p++) begin
        for (int k = 0; k < 3; k++) begin
          pts_r[p][k] <= '0;
        end
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_addr == bce_pkg::REG_POINT_COUNT) begin
        cnt_r <= cfg_data[bce_pkg::CNT_BITS-1:0];
      end else if (32'(pidx) < MAX_POINTS) begin
        for (int k = 0; k < 3; k++) begin
          pts_r[PI_W'(pidx)][k] <= coord_t'(cfg_wide >> (k*COORD_BITS));
        end
      end
    end
  end

  // zero points counts as one; large counts saturate since no stage exists beyond
  assign cnt_eff = (cnt_r == '0) ? bce_pkg::CNT_BITS'(1) : cnt_r;

  // blend stage k is active when k < point count
  always_comb begin
    for (int k = 0; k <= STAGES; k++) begin
      lvl_en[k] = (k > 0) && (32'(cnt_eff) > k);
    end
  end

  // per-stage ready, a stage moves when empty or when its successor moves
  always_comb begin
    rdy[STAGES] = !v_r[STAGES] || out_tready;
    for (int k = STAGES-1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end
  assign in_tready = rdy[0];

  // input saturation of t
  assign tin   = 32'(in_tdata[bce_pkg::T_BITS-1:0]);
  assign t_sat = (tin > ONE_T) ? (FRAC_BITS+1)'(ONE_T) : (FRAC_BITS+1)'(tin);

  // capture stage loads the control points
  always_comb begin
    for (int p = 0; p < MAX_POINTS; p++) begin
      for (int k = 0; k < 3; k++) begin
        q_nxt[0][p][k] = pts_r[p][k];
      end
    end
  end

  // one de casteljau level per stage
  for (genvar s = 1; s <= STAGES; s++) begin : g_lvl
    logic [FRAC_BITS:0] u;
    assign u = (FRAC_BITS+1)'(ONE_T) - t_r[s-1];
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_lane
      for (genvar k = 0; k < 3; k++) begin : g_crd
        if (i < MAX_POINTS-1) begin : g_mix
          logic signed [SUM_W-1:0] ta;
          logic signed [SUM_W-1:0] ub;
          logic signed [SUM_W-1:0] sum;
          assign ta  = $signed({1'b0, t_r[s-1]}) * q_r[s-1][i][k];
          assign ub  = $signed({1'b0, u}) * q_r[s-1][i+1][k];
          assign sum = ta + ub + HALF;
          assign q_nxt[s][i][k] = lvl_en[s] ? coord_t'(sum >>> FRAC_BITS)
                                            : q_r[s-1][i][k];
        end else begin : g_keep
          assign q_nxt[s][i][k] = q_r[s-1][i][k];
        end
      end
    end
  end

  // pipeline registers with valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= STAGES; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s <= STAGES; s++) begin
        if (rdy[s]) begin
          v_r[s] <= (s == 0) ? in_tvalid : v_r[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= STAGES; s++) begin
      if (rdy[s] && ((s == 0) ? in_tvalid : v_r[(s == 0) ? 0 : s-1])) begin
        t_r[s] <= (s == 0) ? t_sat : t_r[(s == 0) ? 0 : s-1];
        for (int p = 0; p < MAX_POINTS; p++) begin
          for (int k = 0; k < 3; k++) begin
            q_r[s][p][k] <= q_nxt[s][p][k];
          end
        end
      end
    end
  end

  // result stream
  assign out_tvalid = v_r[STAGES];
  if (PAD_W > 0) begin : g_pad
    assign out_tdata = {PAD_W'(0), q_r[STAGES][0][2], q_r[STAGES][0][1], q_r[STAGES][0][0]};
  end else begin : g_nopad
    assign out_tdata = {q_r[STAGES][0][2], q_r[STAGES][0][1], q_r[STAGES][0][0]};
  end

`ifndef SYNTHESIS
  // an accepted request always lands in the capture stage
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted request not captured");

  // saturated t never exceeds one
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (32'(t_r[0]) <= ONE_T))
    else $error("t above one in pipeline");

  // a single point curve returns point zero (x coordinate checked)
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cnt_eff == bce_pkg::CNT_BITS'(1))
      |-> (out_tdata[COORD_BITS-1:0] == pts_r[0][0]))
    else $error("single point result differs from point zero");

  // output is empty after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule
